// ===== design/pfc_pkg.sv =====
// Shared types, constants and helper functions of the Playfair encryptor.
`timescale 1ns / 1ps

package pfc_pkg;

  // Grid geometry.
  localparam int GRID_SIDE  = 5;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int LETTERS    = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  // Letter codes with a special role.
  localparam letter_t CODE_A = 5'd0;
  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_X = 5'd23;
  localparam letter_t CODE_Z = 5'd25;

  // Request codes of the input channel.
  typedef enum logic [1:0] {
    REQ_KEY      = 2'd0,
    REQ_KEY_END  = 2'd1,
    REQ_TEXT     = 2'd2,
    REQ_TEXT_END = 2'd3
  } req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK_A,
    S_LOOK_B,
    S_CALC,
    S_GRID_B,
    S_DONE,
    S_PUT,
    S_FILL
  } state_t;

  // One placement into both grid stores.
  typedef struct packed {
    logic    en;
    letter_t letter;
    cell_t   pos;
  } pfc_wr_t;

  // The letter j shares the cell of i.
  function automatic letter_t fold_letter(letter_t c);
    return (c == CODE_J) ? CODE_I : c;
  endfunction

  // Row of a cell index, by comparing against each row start.
  function automatic coord_t cell_row(cell_t pos);
    coord_t row;
    row = '0;
    for (int r = 1; r < GRID_SIDE; r++) begin
      if (pos >= cell_t'(r * GRID_SIDE)) begin
        row = coord_t'(r);
      end
    end
    return row;
  endfunction

  // Column of a cell index, from its row.
  function automatic coord_t cell_col(cell_t pos);
    cell_t rem;
    rem = cell_t'(pos - cell_t'(int'(cell_row(pos)) * GRID_SIDE));
    return rem[2:0];
  endfunction

  // Step one place along a row or column with wrap-around.
  function automatic coord_t wrap_inc(coord_t v);
    return (v == coord_t'(GRID_SIDE - 1)) ? '0 : coord_t'(v + 3'd1);
  endfunction

  // Cell index of a row and column.
  function automatic cell_t cell_at(coord_t row, coord_t col);
    return cell_t'(int'(row) * GRID_SIDE + int'(col));
  endfunction

endpackage

// ===== design/pfc_grid.sv =====
// Grid stores: letter of each cell and cell of each letter, one read port each.
`timescale 1ns / 1ps

module pfc_grid (
  input  logic             clk,
  input  pfc_pkg::pfc_wr_t wr,
  input  pfc_pkg::letter_t cell_rd_addr,
  output pfc_pkg::cell_t   cell_rd_data,
  input  pfc_pkg::cell_t   grid_rd_addr,
  output pfc_pkg::letter_t grid_rd_data
);
  import pfc_pkg::*;

  letter_t key_grid [GRID_CELLS];
  cell_t   letter_cell [LETTERS];
  cell_t   cell_rd_data_r;
  letter_t grid_rd_data_r;

  // A placement writes both stores in the same cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_grid[wr.pos]       <= wr.letter;
      letter_cell[wr.letter] <= wr.pos;
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    cell_rd_data_r <= letter_cell[cell_rd_addr];
    grid_rd_data_r <= key_grid[grid_rd_addr];
  end

  assign cell_rd_data = cell_rd_data_r;
  assign grid_rd_data = grid_rd_data_r;

endmodule

// ===== design/pfc_rule.sv =====
// Playfair rule unit: turns the cells of a pair into the cells of its cipher pair.
`timescale 1ns / 1ps

module pfc_rule (
  input  pfc_pkg::cell_t cell_a,
  input  pfc_pkg::cell_t cell_b,
  output pfc_pkg::cell_t idx_a,
  output pfc_pkg::cell_t idx_b
);
  import pfc_pkg::*;

  coord_t r1, c1, r2, c2;

  assign r1 = cell_row(cell_a);
  assign c1 = cell_col(cell_a);
  assign r2 = cell_row(cell_b);
  assign c2 = cell_col(cell_b);

  // Same row shifts right, same column shifts down, else swap columns.
  always_comb begin
    if (r1 == r2) begin
      idx_a = cell_at(r1, wrap_inc(c1));
      idx_b = cell_at(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      idx_a = cell_at(wrap_inc(r1), c1);
      idx_b = cell_at(wrap_inc(r2), c2);
    end else begin
      idx_a = cell_at(r1, c2);
      idx_b = cell_at(r2, c1);
    end
  end

endmodule

// ===== design/playfair_cipher_encrypt_top.sv =====
// Playfair encryptor top level: request decode, sequencer and result register.
//
// Usage: the input channel (in_valid, in_stall, in_req_type, in_letter) carries
// key letters, a key-end request, plaintext letters and a text-end request.
// Key letters build the 5x5 grid; key end fills the rest with unused letters.
// Text letters are paired (x inserted between doubled letters, x padding at
// text end), and each pair leaves on the result channel (out_valid, out_stall,
// out_cipher_first, out_cipher_second, out_final_pair).
// Sequencing: on key end the sequencer walks all 26 letters, placing each
// unused letter other than j into the grid stores, at most one per cycle. A
// letter that closes a pair, or a text end that flushes one, runs through
// two lookups through the single cell-store read port, the rule step, and
// two lookups through the single grid-store read port, then the result
// register.
// in_stall is high while the sequencer is busy. A finished result waits in
// the output register while out_stall is high; the next item is accepted
// meanwhile, and a following pair holds in its last step until the register
// is free. Reset (rst_n low, synchronous) clears the grid occupancy, the
// open pair and the result register; the grid contents are not cleared.
`timescale 1ns / 1ps

module playfair_cipher_encrypt_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [4:0] in_letter,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_cipher_first,
  output logic [4:0] out_cipher_second,
  output logic       out_final_pair
);
  import pfc_pkg::*;

  state_t    state_r, state_nxt;
  logic [LETTERS-1:0] used_r;
  cell_t     fill_r;
  letter_t   pend_r;
  logic      pend_vld_r;
  letter_t   a_r, b_r;
  logic      fin_r;
  cell_t     ca_r, idx_b_r;
  letter_t   ea_r, eb_r;
  letter_t   walk_r;
  logic      out_valid_r;
  letter_t   out_first_r, out_second_r;
  logic      out_final_r;

  pfc_wr_t   wr;
  letter_t   cell_rd_addr;
  cell_t     cell_rd_data;
  cell_t     grid_rd_addr;
  letter_t   grid_rd_data;
  cell_t     idx_a, idx_b;

  logic      in_xfer;
  logic      out_xfer;
  logic      slot_free;
  req_t      req;
  letter_t   in_c;
  letter_t   place_c;
  logic      can_place;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign req       = req_t'(in_req_type);
  assign in_c      = fold_letter(in_letter);

  // Placement candidate: the key letter when idle, the walk letter when filling.
  assign place_c   = (state_r == S_FILL) ? walk_r : in_c;
  assign can_place = (place_c < letter_t'(LETTERS)) && (fill_r < cell_t'(GRID_CELLS))
                     && !used_r[place_c];

  pfc_grid u_grid (
    .clk          (clk),
    .wr           (wr),
    .cell_rd_addr (cell_rd_addr),
    .cell_rd_data (cell_rd_data),
    .grid_rd_addr (grid_rd_addr),
    .grid_rd_data (grid_rd_data)
  );

  pfc_rule u_rule (
    .cell_a (ca_r),
    .cell_b (cell_rd_data),
    .idx_a  (idx_a),
    .idx_b  (idx_b)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, store addresses and placements.
  always_comb begin
    state_nxt    = state_r;
    wr           = '0;
    wr.letter    = place_c;
    wr.pos       = fill_r;
    cell_rd_addr = a_r;
    grid_rd_addr = idx_a;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (req)
            REQ_KEY: begin
              wr.en = can_place;
            end
            REQ_KEY_END: begin
              state_nxt = S_FILL;
            end
            REQ_TEXT: begin
              if ((in_c < letter_t'(LETTERS)) && pend_vld_r) begin
                state_nxt = S_LOOK_A;
              end
            end
            REQ_TEXT_END: begin
              if (pend_vld_r) begin
                state_nxt = S_LOOK_A;
              end
            end
          endcase
        end
      end
      S_LOOK_A: begin
        cell_rd_addr = a_r;
        state_nxt    = S_LOOK_B;
      end
      S_LOOK_B: begin
        cell_rd_addr = b_r;
        state_nxt    = S_CALC;
      end
      S_CALC: begin
        grid_rd_addr = idx_a;
        state_nxt    = S_GRID_B;
      end
      S_GRID_B: begin
        grid_rd_addr = idx_b_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        wr.en = can_place && (walk_r != CODE_J);
        if (walk_r == CODE_Z) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Grid occupancy and fill count follow each placement.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      fill_r <= '0;
    end else if (wr.en) begin
      used_r[wr.letter] <= 1'b1;
      fill_r            <= cell_t'(fill_r + 5'd1);
    end
  end

  // Pair building on text items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      pend_vld_r <= 1'b0;
    end else if (in_xfer) begin
      if (req == REQ_TEXT && in_c < letter_t'(LETTERS)) begin
        if (!pend_vld_r) begin
          pend_r     <= in_c;
          pend_vld_r <= 1'b1;
        end else if (in_c != pend_r) begin
          pend_vld_r <= 1'b0;
        end
      end else if (req == REQ_TEXT_END) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  // Pair operands, latched at every input transfer; those of the transfer that closes a pair are used.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_r   <= pend_r;
      b_r   <= (req == REQ_TEXT && in_c != pend_r) ? in_c : CODE_X;
      fin_r <= (req == REQ_TEXT_END);
    end
  end

  // Fill walk counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= CODE_A;
    end else if (state_r == S_FILL) begin
      walk_r <= (walk_r == CODE_Z) ? CODE_A : letter_t'(walk_r + 5'd1);
    end
  end

  // Intermediate results of the pair lookup.
  always_ff @(posedge clk) begin
    if (state_r == S_LOOK_B) begin
      ca_r <= cell_rd_data;
    end
    if (state_r == S_CALC) begin
      idx_b_r <= idx_b;
    end
    if (state_r == S_GRID_B) begin
      ea_r <= grid_rd_data;
    end
    if (state_r == S_DONE) begin
      eb_r <= grid_rd_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_PUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUT && slot_free) begin
      out_first_r  <= ea_r;
      out_second_r <= eb_r;
      out_final_r  <= fin_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cipher_first  = out_first_r;
  assign out_cipher_second = out_second_r;
  assign out_final_pair    = out_final_r;

`ifndef SYNTHESIS
  // The grid never holds more letters than it has cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cell_t'(GRID_CELLS))
    else $error("grid fill count beyond cell count");

  // Every placed letter took exactly one cell.
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(fill_r))
    else $error("occupancy bits disagree with fill count");

  // The letter j is never placed.
  a_no_j: assert property (@(posedge clk) disable iff (!rst_n)
    !used_r[CODE_J])
    else $error("letter j placed in grid");

  // A new result only appears after the sequencer delivered it.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUT))
    else $error("result appeared without a delivery step");
`endif

endmodule
